>>> hdl/irc_pkg.sv
// Package for the interval room counter: shared widths and default parameter values.
// No dependencies.
package irc_pkg;
  localparam int unsigned DEF_MAX_JOBS  = 1024;
  localparam int unsigned DEF_TIME_BITS = 16;
  localparam int unsigned COUNT_W       = 11;
  localparam int unsigned COUNT_MAX     = 2047;
endpackage

>>> hdl/irc_if.sv
// Channel interfaces for the interval room counter: job input and room count result.
// Depends on irc_pkg.
interface irc_job_if #(
  parameter int unsigned TIME_BITS = irc_pkg::DEF_TIME_BITS
);
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] job_begin;
  logic [TIME_BITS-1:0] job_end;
  logic                 last_job;
  modport source (output valid, job_begin, job_end, last_job, input ready);
  modport sink   (input valid, job_begin, job_end, last_job, output ready);
endinterface

interface irc_res_if;
  import irc_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] room_count;
  logic               overflow;
  modport source (output valid, room_count, overflow, input ready);
  modport sink   (input valid, room_count, overflow, output ready);
endinterface

>>> hdl/interval_room_count_greedy_core.sv
// Interval room counter top level: job store, end-time ordering and greedy room passes.
// Depends on irc_pkg and the interfaces in irc_if.sv.
//
//  channel   dir  fields                              transaction
//  in_job    in   job_begin, job_end, last_job        one job
//  out_res   out  room_count, overflow                one count per job set
//
// Jobs load one per cycle. After the last job, the jobs are ordered by (end, load index)
// with one end-store read and one compare per job for each pick (S_SRD, S_SCMP), then
// each greedy pass takes every job through order read, job read and decide. in_job.ready
// is low from the last job until the count is taken. Synchronous active-low reset; no
// clearing pass, the placed flag of each entry is cleared as the job is written.
module interval_room_count_greedy_core #(
  parameter int unsigned MAX_JOBS  = irc_pkg::DEF_MAX_JOBS,
  parameter int unsigned TIME_BITS = irc_pkg::DEF_TIME_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  irc_job_if.sink      in_job,
  irc_res_if.source    out_res
);
  import irc_pkg::*;

  localparam int unsigned IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CW = $clog2(MAX_JOBS + 1);
  localparam int unsigned KW = TIME_BITS + IW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRD  = 4'd1;
  localparam logic [3:0] S_SCMP = 4'd2;
  localparam logic [3:0] S_SWR  = 4'd3;
  localparam logic [3:0] S_GIDX = 4'd4;
  localparam logic [3:0] S_GJOB = 4'd5;
  localparam logic [3:0] S_GDEC = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;

  // stores
  logic [TIME_BITS-1:0] begin_mem [MAX_JOBS];
  logic [TIME_BITS-1:0] end_mem   [MAX_JOBS];
  logic                 placed_mem[MAX_JOBS];
  logic [IW-1:0]        ord_mem   [MAX_JOBS];

  logic [TIME_BITS-1:0] begin_rd_r, end_rd_r;
  logic                 placed_rd_r;
  logic [IW-1:0]        ord_rd_r;

  logic [3:0]           state_r, state_nxt;
  logic [CW-1:0]        total_r, total_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [IW-1:0]        nm1_r, nm1_nxt;
  logic [IW-1:0]        p_r, p_nxt;
  logic [IW-1:0]        o_r, o_nxt;
  logic [IW-1:0]        i_r, i_nxt;
  logic [KW-1:0]        last_key_r, last_key_nxt;
  logic                 have_last_r, have_last_nxt;
  logic [KW-1:0]        best_key_r, best_key_nxt;
  logic                 best_v_r, best_v_nxt;
  logic [CW-1:0]        left_r, left_nxt;
  logic [CW-1:0]        rooms_r, rooms_nxt;
  logic [TIME_BITS-1:0] free_r, free_nxt;
  logic                 empty_r, empty_nxt;
  logic [COUNT_W-1:0]   cnt_r, cnt_nxt;

  logic                 in_acc, out_acc, store_ok;
  logic [IW-1:0]        job_addr;
  logic [KW-1:0]        cand_key;
  logic                 fits;
  logic [CW-1:0]        left_dec;
  logic [31:0]          rooms_ext;

  assign in_acc   = in_job.valid && in_job.ready;
  assign out_acc  = out_res.valid && out_res.ready;
  assign store_ok = (32'(total_r) < MAX_JOBS);
  assign job_addr = (state_r == S_SRD) ? p_r : ord_rd_r;
  assign cand_key = {end_rd_r, p_r};
  assign fits     = !placed_rd_r && (empty_r || (begin_rd_r > free_r));
  assign left_dec = left_r - CW'(1);
  assign rooms_ext = 32'(rooms_r) + 32'd1;

  assign in_job.ready       = (state_r == S_IDLE);
  assign out_res.valid      = (state_r == S_OUT);
  assign out_res.room_count = cnt_r;
  assign out_res.overflow   = ovf_r;

  // store writes and registered reads
  always_ff @(posedge clk) begin
    if (in_acc && store_ok) begin
      begin_mem[total_r[IW-1:0]] <= in_job.job_begin;
      end_mem[total_r[IW-1:0]]   <= in_job.job_end;
    end
    begin_rd_r <= begin_mem[job_addr];
    end_rd_r   <= end_mem[job_addr];
  end

  always_ff @(posedge clk) begin
    if (in_acc && store_ok) begin
      placed_mem[total_r[IW-1:0]] <= 1'b0;
    end else if (state_r == S_GDEC && fits) begin
      placed_mem[ord_rd_r] <= 1'b1;
    end
    placed_rd_r <= placed_mem[job_addr];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SWR) begin
      ord_mem[o_r] <= best_key_r[IW-1:0];
    end
    ord_rd_r <= ord_mem[i_r];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    ovf_nxt       = ovf_r;
    nm1_nxt       = nm1_r;
    p_nxt         = p_r;
    o_nxt         = o_r;
    i_nxt         = i_r;
    last_key_nxt  = last_key_r;
    have_last_nxt = have_last_r;
    best_key_nxt  = best_key_r;
    best_v_nxt    = best_v_r;
    left_nxt      = left_r;
    rooms_nxt     = rooms_r;
    free_nxt      = free_r;
    empty_nxt     = empty_r;
    cnt_nxt       = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (store_ok) total_nxt = total_r + CW'(1);
          else          ovf_nxt   = 1'b1;
          if (in_job.last_job) begin
            nm1_nxt       = IW'(total_nxt - CW'(1));
            p_nxt         = '0;
            o_nxt         = '0;
            have_last_nxt = 1'b0;
            best_v_nxt    = 1'b0;
            if (total_nxt == '0) begin
              cnt_nxt   = '0;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_SRD;
            end
          end
        end
      end
      S_SRD: state_nxt = S_SCMP;
      // keep the smallest key above the previous pick
      S_SCMP: begin
        if ((!have_last_r || cand_key > last_key_r) &&
            (!best_v_r || cand_key < best_key_r)) begin
          best_key_nxt = cand_key;
          best_v_nxt   = 1'b1;
        end
        if (p_r == nm1_r) begin
          state_nxt = S_SWR;
        end else begin
          p_nxt     = p_r + IW'(1);
          state_nxt = S_SRD;
        end
      end
      S_SWR: begin
        last_key_nxt  = best_key_r;
        have_last_nxt = 1'b1;
        best_v_nxt    = 1'b0;
        p_nxt         = '0;
        if (o_r == nm1_r) begin
          i_nxt     = '0;
          empty_nxt = 1'b1;
          free_nxt  = '0;
          left_nxt  = total_r;
          rooms_nxt = '0;
          state_nxt = S_GIDX;
        end else begin
          o_nxt     = o_r + IW'(1);
          state_nxt = S_SRD;
        end
      end
      S_GIDX: state_nxt = S_GJOB;
      S_GJOB: state_nxt = S_GDEC;
      // greedy placement into the open room
      S_GDEC: begin
        if (fits) begin
          free_nxt  = end_rd_r;
          empty_nxt = 1'b0;
          left_nxt  = left_dec;
        end
        if (i_r == nm1_r) begin
          rooms_nxt = rooms_r + CW'(1);
          i_nxt     = '0;
          empty_nxt = 1'b1;
          if (left_nxt == '0) begin
            cnt_nxt   = (rooms_ext > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : rooms_ext[COUNT_W-1:0];
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_GIDX;
          end
        end else begin
          i_nxt     = i_r + IW'(1);
          state_nxt = S_GIDX;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          total_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    nm1_r       <= nm1_nxt;
    p_r         <= p_nxt;
    o_r         <= o_nxt;
    i_r         <= i_nxt;
    last_key_r  <= last_key_nxt;
    have_last_r <= have_last_nxt;
    best_key_r  <= best_key_nxt;
    best_v_r    <= best_v_nxt;
    left_r      <= left_nxt;
    rooms_r     <= rooms_nxt;
    free_r      <= free_nxt;
    empty_r     <= empty_nxt;
    cnt_r       <= cnt_nxt;
  end

`ifndef SYNTHESIS
  a_last_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_job.last_job) |=> (state_r != S_IDLE))
    else $error("last job did not start processing");

  a_left_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GDEC) |-> (left_r <= total_r))
    else $error("jobs left exceeds job total");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && total_r != '0) |-> (out_res.room_count != '0))
    else $error("zero rooms for a non-empty set");
`endif
endmodule

>>> tb/interval_room_count_greedy_core_test.sv
`timescale 1ns / 1ps
// Testbench for interval_room_count_greedy_core: job sets are loaded and each room count
// is checked against a scoreboard that sorts and packs the jobs itself.
// Depends on irc_pkg, irc_if.sv and the core.
module interval_room_count_greedy_core_test;
  import irc_pkg::*;

  localparam int unsigned JOB_CAP   = DEF_MAX_JOBS;
  localparam int unsigned TW        = DEF_TIME_BITS;
  localparam int unsigned IDLE_MAX  = 8_000_000; // covers ordering a full store
  localparam int unsigned RAND_JOBS = 700;

  typedef struct packed {
    logic [COUNT_W-1:0] rooms;
    logic               ovf;
  } room_result_t;

  // Scoreboard: keeps the current set, predicts its room count on the last job
  class room_scoreboard;
    logic [TW-1:0] set_begin[$];
    logic [TW-1:0] set_end[$];
    bit            set_ovf;
    room_result_t  pending[$];
    int            errors;

    function int unsigned pack_rooms();
      int unsigned n, left, rooms, cur, k;
      int unsigned ord[];
      bit          placed[];
      bit          empty;
      logic [TW-1:0] free_at;
      n = set_begin.size();
      ord = new[n];
      placed = new[n];
      // stable insertion sort on end time
      for (int unsigned i = 0; i < n; i++) ord[i] = i;
      for (int unsigned i = 1; i < n; i++) begin
        cur = ord[i];
        k = i;
        while (k > 0 && set_end[ord[k-1]] > set_end[cur]) begin
          ord[k] = ord[k-1];
          k--;
        end
        ord[k] = cur;
      end
      left = n;
      rooms = 0;
      while (left > 0) begin
        empty = 1;
        free_at = '0;
        foreach (ord[i]) begin
          if (!placed[ord[i]] && (empty || set_begin[ord[i]] > free_at)) begin
            free_at = set_end[ord[i]];
            empty = 0;
            placed[ord[i]] = 1;
            left--;
          end
        end
        rooms++;
      end
      return (rooms > COUNT_MAX) ? COUNT_MAX : rooms;
    endfunction

    function void note_job(logic [TW-1:0] b, logic [TW-1:0] e, logic last);
      room_result_t r;
      if (set_begin.size() < JOB_CAP) begin
        set_begin.push_back(b);
        set_end.push_back(e);
      end else begin
        set_ovf = 1;
      end
      if (last) begin
        r.rooms = COUNT_W'(pack_rooms());
        r.ovf = set_ovf;
        pending.push_back(r);
        set_begin.delete();
        set_end.delete();
        set_ovf = 0;
      end
    endfunction

    function void check_count(logic [COUNT_W-1:0] rooms, logic ovf);
      room_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected count rooms=%0d overflow=%0b", $time, rooms, ovf);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (rooms !== want.rooms) begin
        $display("%0t: room_count expected %0d actual %0d", $time, want.rooms, rooms);
        errors++;
      end
      if (ovf !== want.ovf) begin
        $display("%0t: overflow expected %0b actual %0b", $time, want.ovf, ovf);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  irc_job_if #(.TIME_BITS(TW)) job_ch();
  irc_res_if                   res_ch();
  room_scoreboard              sb;
  int unsigned                 burst_left;
  int unsigned                 idle_cycles;
  int unsigned                 stall_mode;
  int unsigned                 mode_left;

  interval_room_count_greedy_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_job (job_ch),
    .out_res(res_ch)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Monitors: note accepted jobs, check counts, watchdog on idle cycles
  always @(posedge clk) begin
    if (rst_n && job_ch.valid && job_ch.ready)
      sb.note_job(job_ch.job_begin, job_ch.job_end, job_ch.last_job);
    if (rst_n && res_ch.valid && res_ch.ready)
      sb.check_count(res_ch.room_count, res_ch.overflow);
    if ((job_ch.valid && job_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_MAX) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver stalls: runs of always-ready, coin toss and long holds
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left <= $urandom_range(5, 60);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: res_ch.ready <= 1'b1;
      1: res_ch.ready <= 1'($urandom_range(0, 1));
      default: res_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Sender: bursts of random length, gaps with junk payload
  task automatic send_job(logic [TW-1:0] b, logic [TW-1:0] e, logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      job_ch.valid <= 1'b0;
      repeat (gap) begin
        job_ch.job_begin <= TW'($urandom);
        job_ch.job_end <= TW'($urandom);
        job_ch.last_job <= 1'($urandom_range(0, 1));
        @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 12);
    end
    burst_left--;
    job_ch.valid <= 1'b1;
    job_ch.job_begin <= b;
    job_ch.job_end <= e;
    job_ch.last_job <= last;
    do @(posedge clk); while (!job_ch.ready);
  endtask

  function automatic logic [TW-1:0] pick_time();
    case ($urandom_range(0, 5))
      0: return TW'($urandom);
      1: return TW'({TW{1'b1}} - $urandom_range(0, 40));
      default: return TW'($urandom_range(0, 63));
    endcase
  endfunction

  initial begin
    int unsigned sent, len;
    logic [TW-1:0] b, e;
    sb = new();
    rst_n = 0;
    idle_cycles = 0;
    stall_mode = 0;
    mode_left = 0;
    burst_left = 0;
    job_ch.valid = 0;
    job_ch.job_begin = '0;
    job_ch.job_end = '0;
    job_ch.last_job = 0;
    res_ch.ready = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // single job starting at time zero: a fresh room must take it
    send_job('0, '0, 1);
    // extremes, begin after end, and begin equal to a previous end (no fit)
    send_job({TW{1'b1}}, {TW{1'b1}}, 0);
    send_job(16'd100, 16'd5, 0);
    send_job(16'd5, 16'd10, 0);
    send_job(16'd10, 16'd20, 1);
    // equal ends keep load order; tie with all-ones times
    send_job(16'd3, 16'd50, 0);
    send_job(16'd1, 16'd50, 0);
    send_job(16'd51, {TW{1'b1}}, 0);
    send_job(16'd0, {TW{1'b1}}, 0);
    send_job({TW{1'b1}}, 16'd0, 1);
    // fully overlapping jobs: one room each
    repeat (5) send_job(16'd0, {TW{1'b1}}, 0);
    send_job(16'd0, {TW{1'b1}}, 1);
    // full store plus one dropped final job; disjoint jobs keep it to one pass
    for (int unsigned i = 0; i < JOB_CAP; i++)
      send_job(TW'(2 * i), TW'(2 * i), 0);
    send_job(16'd7, 16'd9, 1);

    // random sets, mostly small, a few larger
    sent = 0;
    while (sent < RAND_JOBS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      for (int unsigned j = 0; j < len; j++) begin
        b = pick_time();
        e = ($urandom_range(0, 3) == 0) ? pick_time() : TW'(b + $urandom_range(0, 20));
        send_job(b, e, j == len - 1);
        sent++;
      end
    end
    job_ch.valid <= 1'b0;

    // wait for the monitor to note the final job, then drain the counts
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
